[rtl/slnr_pkg.sv]
`timescale 1ns / 1ps
package slnr_pkg;

	localparam int unsigned LEN_W        = 24;
	localparam int unsigned MIX_W        = 18;
	localparam int unsigned RATE_W       = 16;
	localparam int unsigned DLEN_W       = 32;
	localparam int unsigned ACC_W        = 48;
	localparam int unsigned PROD_W       = LEN_W + MIX_W;
	localparam int unsigned MAX_UPSAMPLE = 63;
	localparam int unsigned NEMIT_W      = 6;

	localparam logic [MIX_W-1:0]  MIX_RESET   = 18'd44100;
	localparam logic [7:0]        FMT_BYTE0   = 8'h03;
	localparam logic [7:0]        FMT_BYTE1   = 8'h00;
	localparam logic [LEN_W-1:0]  POS_FMT0    = 24'd0;
	localparam logic [LEN_W-1:0]  POS_FMT1    = 24'd1;
	localparam logic [LEN_W-1:0]  POS_RATE_LO = 24'd2;
	localparam logic [LEN_W-1:0]  POS_RATE_HI = 24'd3;
	localparam logic [LEN_W-1:0]  POS_LEN0    = 24'd4;
	localparam logic [LEN_W-1:0]  POS_LEN1    = 24'd5;
	localparam logic [LEN_W-1:0]  POS_LEN2    = 24'd6;
	localparam logic [LEN_W-1:0]  POS_LEN3    = 24'd7;
	localparam logic [LEN_W-1:0]  HDR_BYTES   = 24'd24;
	localparam logic [LEN_W-1:0]  MIN_SIZE    = 24'd8;
	localparam logic [DLEN_W-1:0] MIN_LEN     = 32'd48;
	localparam logic [DLEN_W-1:0] LEN_SKIP    = 32'd32;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_FIN    = 2'd1,
		KIND_BAD    = 2'd2,
		KIND_RATE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_ACCEPT,
		ST_START,
		ST_DECODE,
		ST_LEN,
		ST_MUL,
		ST_DIV1,
		ST_WAIT1,
		ST_TAKE_E,
		ST_DIV2,
		ST_WAIT2,
		ST_TAKE_R,
		ST_EMIT,
		ST_FIN,
		ST_REJECT
	} state_t;

	typedef struct packed {
		logic   accept;
		logic   start;
		logic   hdr_step;
		logic   len_sub;
		logic   mul;
		logic   div_e;
		logic   div_r;
		logic   take_e;
		logic   take_r;
		logic   data_begin;
		logic   emit_sample;
		logic   emit_single;
		kind_t  kind;
	} cmd_t;

	typedef struct packed {
		logic   in_valid;
		logic   first;
		logic   size_short;
		phase_t phase;
		logic   hdr_bad;
		logic   hdr_at_len;
		logic   len_bad;
		logic   src_zero;
		logic   div_done;
		logic   e_bad;
		logic   r_bad;
		logic   more;
		logic   is_fin;
		logic   slot_free;
	} status_t;

endpackage

[rtl/slnr_in_if.sv]
`timescale 1ns / 1ps
interface slnr_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  lump_byte;
	logic        first_byte;
	logic [23:0] lump_size;

	modport source (output valid, lump_byte, first_byte, lump_size, input ready);
	modport sink (input valid, lump_byte, first_byte, lump_size, output ready);
endinterface

[rtl/slnr_out_if.sv]
`timescale 1ns / 1ps
interface slnr_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [7:0]  sample;
	logic [23:0]        sample_index;
	logic               last;

	modport source (output valid, kind, sample, sample_index, last, input ready);
	modport sink (input valid, kind, sample, sample_index, last, output ready);
endinterface

[rtl/slnr_div.sv]
`timescale 1ns / 1ps
module slnr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [slnr_pkg::PROD_W-1:0]      num,
	input  logic [slnr_pkg::LEN_W-1:0]       den,
	output logic                             done,
	output logic [slnr_pkg::PROD_W-1:0]      quo
);
	localparam int unsigned CNT_W = $clog2(slnr_pkg::PROD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(slnr_pkg::PROD_W - 1);

	logic [slnr_pkg::LEN_W-1:0]  rem_q;
	logic [slnr_pkg::LEN_W-1:0]  den_q;
	logic [slnr_pkg::PROD_W-1:0] quo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [slnr_pkg::LEN_W:0]    trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[slnr_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? slnr_pkg::LEN_W'(trial - {1'b0, den_q})
			              : trial[slnr_pkg::LEN_W-1:0];
			quo_q <= {quo_q[slnr_pkg::PROD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

[rtl/slnr_dp.sv]
`timescale 1ns / 1ps
module slnr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slnr_pkg::cmd_t                cmd,
	output slnr_pkg::status_t             st,
	slnr_in_if.sink                       in_ch,
	slnr_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [slnr_pkg::MIX_W-1:0]    cfg_wdata
);
	logic [slnr_pkg::MIX_W-1:0]   mix_q;
	slnr_pkg::phase_t             phase_q;
	logic [7:0]                   byte_q;
	logic                         first_q;
	logic [slnr_pkg::LEN_W-1:0]   insize_q;
	logic [slnr_pkg::LEN_W-1:0]   pos_q;
	logic [slnr_pkg::LEN_W-1:0]   size_q;
	logic [slnr_pkg::RATE_W-1:0]  src_q;
	logic [slnr_pkg::DLEN_W-1:0]  len_q;
	logic [slnr_pkg::LEN_W-1:0]   exp_q;
	logic [slnr_pkg::DLEN_W-1:0]  step_q;
	logic [slnr_pkg::LEN_W-1:0]   cnt_q;
	logic [slnr_pkg::ACC_W-1:0]   acc_q;
	logic [slnr_pkg::LEN_W-1:0]   k_q;
	logic [slnr_pkg::NEMIT_W-1:0] nemit_q;
	logic [slnr_pkg::PROD_W-1:0]  prod_q;

	logic                         out_valid_q;
	slnr_pkg::kind_t              out_kind_q;
	logic [7:0]                   out_sample_q;
	logic [slnr_pkg::LEN_W-1:0]   out_index_q;
	logic                         out_last_q;

	logic                         div_start;
	logic [slnr_pkg::PROD_W-1:0]  div_num;
	logic [slnr_pkg::LEN_W-1:0]   div_den;
	logic                         div_done;
	logic [slnr_pkg::PROD_W-1:0]  div_quo;

	logic                         in_take;
	logic [slnr_pkg::ACC_W-1:0]   acc_nx;
	logic [slnr_pkg::LEN_W:0]     cnt_nx;
	logic [slnr_pkg::NEMIT_W:0]   nemit_nx;
	logic                         more_nx;
	logic [slnr_pkg::ACC_W-1:0]   r_scaled;

	slnr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign div_start = cmd.div_e | cmd.div_r;
	assign div_num   = cmd.div_e ? prod_q
	                             : slnr_pkg::PROD_W'({len_q[slnr_pkg::LEN_W-1:0], 8'h00});
	assign div_den   = cmd.div_e ? slnr_pkg::LEN_W'(src_q) : exp_q;

	assign in_take  = in_ch.valid & cmd.accept;
	assign acc_nx   = acc_q + slnr_pkg::ACC_W'(step_q);
	assign cnt_nx   = {1'b0, cnt_q} + 1'b1;
	assign nemit_nx = {1'b0, nemit_q} + 1'b1;
	assign more_nx  = (cnt_nx < {1'b0, exp_q})
	               && (nemit_nx < (slnr_pkg::NEMIT_W+1)'(slnr_pkg::MAX_UPSAMPLE))
	               && (acc_nx[slnr_pkg::ACC_W-1:8] == (slnr_pkg::ACC_W-8)'(k_q));
	assign r_scaled = slnr_pkg::ACC_W'(div_quo) * slnr_pkg::ACC_W'(slnr_pkg::MAX_UPSAMPLE);

	always_comb begin
		st            = '0;
		st.in_valid   = in_ch.valid;
		st.first      = first_q;
		st.size_short = insize_q < slnr_pkg::MIN_SIZE;
		st.phase      = phase_q;
		st.hdr_bad    = ((pos_q == slnr_pkg::POS_FMT0) && (byte_q != slnr_pkg::FMT_BYTE0))
		             || ((pos_q == slnr_pkg::POS_FMT1) && (byte_q != slnr_pkg::FMT_BYTE1));
		st.hdr_at_len = pos_q == slnr_pkg::POS_LEN3;
		st.len_bad    = (len_q > slnr_pkg::DLEN_W'(size_q - slnr_pkg::MIN_SIZE))
		             || (len_q <= slnr_pkg::MIN_LEN);
		st.src_zero   = src_q == '0;
		st.div_done   = div_done;
		st.e_bad      = (div_quo == '0) || (div_quo[slnr_pkg::PROD_W-1:slnr_pkg::LEN_W] != '0);
		st.r_bad      = r_scaled < slnr_pkg::ACC_W'(256);
		st.more       = (cnt_q < exp_q)
		             && (nemit_q < slnr_pkg::NEMIT_W'(slnr_pkg::MAX_UPSAMPLE))
		             && (acc_q[slnr_pkg::ACC_W-1:8] == (slnr_pkg::ACC_W-8)'(k_q));
		st.is_fin     = ({9'b0, k_q} + 33'd1) >= {1'b0, len_q};
		st.slot_free  = !out_valid_q || out_ch.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q       <= slnr_pkg::MIX_RESET;
			phase_q     <= slnr_pkg::PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mix_q <= cfg_wdata;
			end
			if (cmd.start) begin
				phase_q <= slnr_pkg::PH_HEADER;
			end else if (cmd.emit_single) begin
				phase_q <= slnr_pkg::PH_IDLE;
			end else if (cmd.hdr_step && pos_q == slnr_pkg::HDR_BYTES - 1'b1) begin
				phase_q <= slnr_pkg::PH_DATA;
			end
			if (cmd.emit_sample || cmd.emit_single) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_q   <= in_ch.lump_byte;
			first_q  <= in_ch.first_byte;
			insize_q <= in_ch.lump_size;
		end
		if (cmd.start) begin
			pos_q  <= '0;
			size_q <= insize_q;
			src_q  <= '0;
			len_q  <= '0;
			exp_q  <= '0;
			step_q <= '0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end
		if (cmd.hdr_step) begin
			pos_q <= pos_q + 1'b1;
			case (pos_q)
				slnr_pkg::POS_RATE_LO: src_q[7:0]   <= byte_q;
				slnr_pkg::POS_RATE_HI: src_q[15:8]  <= byte_q;
				slnr_pkg::POS_LEN0:    len_q[7:0]   <= byte_q;
				slnr_pkg::POS_LEN1:    len_q[15:8]  <= byte_q;
				slnr_pkg::POS_LEN2:    len_q[23:16] <= byte_q;
				slnr_pkg::POS_LEN3:    len_q[31:24] <= byte_q;
				default: ;
			endcase
		end
		if (cmd.len_sub) begin
			len_q <= len_q - slnr_pkg::LEN_SKIP;
		end
		if (cmd.mul) begin
			prod_q <= slnr_pkg::PROD_W'(len_q[slnr_pkg::LEN_W-1:0])
			        * slnr_pkg::PROD_W'(mix_q);
		end
		if (cmd.take_e) begin
			exp_q <= div_quo[slnr_pkg::LEN_W-1:0];
		end
		if (cmd.take_r) begin
			step_q <= div_quo[slnr_pkg::DLEN_W-1:0];
		end
		if (cmd.data_begin) begin
			k_q     <= pos_q - slnr_pkg::HDR_BYTES;
			pos_q   <= pos_q + 1'b1;
			nemit_q <= '0;
		end
		if (cmd.emit_sample) begin
			out_kind_q   <= slnr_pkg::KIND_SAMPLE;
			out_sample_q <= byte_q ^ 8'h80;
			out_index_q  <= cnt_q;
			out_last_q   <= !more_nx && !st.is_fin;
			cnt_q        <= cnt_nx[slnr_pkg::LEN_W-1:0];
			nemit_q      <= nemit_nx[slnr_pkg::NEMIT_W-1:0];
			acc_q        <= acc_nx;
		end else if (cmd.emit_single) begin
			out_kind_q   <= cmd.kind;
			out_sample_q <= '0;
			out_index_q  <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign in_ch.ready         = cmd.accept;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = out_kind_q;
	assign out_ch.sample       = out_sample_q;
	assign out_ch.sample_index = out_index_q;
	assign out_ch.last         = out_last_q;

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sample || cmd.emit_single) |-> st.slot_free)
		else $error("result loaded over a waiting result");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slnr_pkg::PH_DATA && cmd.emit_sample) |=> cnt_q <= exp_q)
		else $error("output count passed expanded length");
	a_nemit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sample |=> nemit_q <= slnr_pkg::NEMIT_W'(slnr_pkg::MAX_UPSAMPLE))
		else $error("too many samples for one byte");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_single |=> out_valid_q && out_last_q)
		else $error("status result without last");
endmodule

[rtl/slnr_ctrl.sv]
`timescale 1ns / 1ps
module slnr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slnr_pkg::status_t    st,
	output slnr_pkg::cmd_t       cmd
);
	slnr_pkg::state_t state_q, state_d;
	slnr_pkg::kind_t  rej_kind_q, rej_kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slnr_pkg::ST_ACCEPT;
			rej_kind_q <= slnr_pkg::KIND_BAD;
		end else begin
			state_q    <= state_d;
			rej_kind_q <= rej_kind_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rej_kind_d = rej_kind_q;
		cmd        = '0;
		cmd.kind   = (state_q == slnr_pkg::ST_FIN) ? slnr_pkg::KIND_FIN : rej_kind_q;
		case (state_q)
			slnr_pkg::ST_ACCEPT: begin
				cmd.accept = 1'b1;
				if (st.in_valid) begin
					state_d = slnr_pkg::ST_START;
				end
			end
			slnr_pkg::ST_START: begin
				if (st.first) begin
					cmd.start = 1'b1;
					if (st.size_short) begin
						rej_kind_d = slnr_pkg::KIND_BAD;
						state_d    = slnr_pkg::ST_REJECT;
					end else begin
						state_d = slnr_pkg::ST_DECODE;
					end
				end else begin
					state_d = slnr_pkg::ST_DECODE;
				end
			end
			slnr_pkg::ST_DECODE: begin
				case (st.phase)
					slnr_pkg::PH_HEADER: begin
						cmd.hdr_step = 1'b1;
						if (st.hdr_bad) begin
							rej_kind_d = slnr_pkg::KIND_BAD;
							state_d    = slnr_pkg::ST_REJECT;
						end else if (st.hdr_at_len) begin
							state_d = slnr_pkg::ST_LEN;
						end else begin
							state_d = slnr_pkg::ST_ACCEPT;
						end
					end
					slnr_pkg::PH_DATA: begin
						cmd.data_begin = 1'b1;
						state_d        = slnr_pkg::ST_EMIT;
					end
					default: state_d = slnr_pkg::ST_ACCEPT;
				endcase
			end
			slnr_pkg::ST_LEN: begin
				if (st.len_bad) begin
					rej_kind_d = slnr_pkg::KIND_BAD;
					state_d    = slnr_pkg::ST_REJECT;
				end else if (st.src_zero) begin
					rej_kind_d = slnr_pkg::KIND_RATE;
					state_d    = slnr_pkg::ST_REJECT;
				end else begin
					cmd.len_sub = 1'b1;
					state_d     = slnr_pkg::ST_MUL;
				end
			end
			slnr_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = slnr_pkg::ST_DIV1;
			end
			slnr_pkg::ST_DIV1: begin
				cmd.div_e = 1'b1;
				state_d   = slnr_pkg::ST_WAIT1;
			end
			slnr_pkg::ST_WAIT1: begin
				if (st.div_done) begin
					state_d = slnr_pkg::ST_TAKE_E;
				end
			end
			slnr_pkg::ST_TAKE_E: begin
				if (st.e_bad) begin
					rej_kind_d = slnr_pkg::KIND_RATE;
					state_d    = slnr_pkg::ST_REJECT;
				end else begin
					cmd.take_e = 1'b1;
					state_d    = slnr_pkg::ST_DIV2;
				end
			end
			slnr_pkg::ST_DIV2: begin
				cmd.div_r = 1'b1;
				state_d   = slnr_pkg::ST_WAIT2;
			end
			slnr_pkg::ST_WAIT2: begin
				if (st.div_done) begin
					state_d = slnr_pkg::ST_TAKE_R;
				end
			end
			slnr_pkg::ST_TAKE_R: begin
				if (st.r_bad) begin
					rej_kind_d = slnr_pkg::KIND_RATE;
					state_d    = slnr_pkg::ST_REJECT;
				end else begin
					cmd.take_r = 1'b1;
					state_d    = slnr_pkg::ST_ACCEPT;
				end
			end
			slnr_pkg::ST_EMIT: begin
				if (st.more) begin
					cmd.emit_sample = st.slot_free;
				end else if (st.is_fin) begin
					state_d = slnr_pkg::ST_FIN;
				end else begin
					state_d = slnr_pkg::ST_ACCEPT;
				end
			end
			slnr_pkg::ST_FIN, slnr_pkg::ST_REJECT: begin
				if (st.slot_free) begin
					cmd.emit_single = 1'b1;
					state_d         = slnr_pkg::ST_ACCEPT;
				end
			end
			default: state_d = slnr_pkg::ST_ACCEPT;
		endcase
	end

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (state_q == slnr_pkg::ST_ACCEPT))
		else $error("request taken outside accept state");
	a_take_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slnr_pkg::ST_TAKE_E || state_q == slnr_pkg::ST_TAKE_R)
		|-> $past(st.div_done))
		else $error("quotient used before divider finished");
	a_status_exit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_single |=> state_q == slnr_pkg::ST_ACCEPT)
		else $error("status result did not end the request");
endmodule

[rtl/sound_lump_nearest_resampler_core.sv]
`timescale 1ns / 1ps
// channel  dir  payload                                   handshake
// in_ch    in   lump_byte, first_byte, lump_size          valid / ready
// out_ch   out  kind, sample, sample_index, last          valid / ready
// cfg      in   cfg_wdata (mixer_rate)                    cfg_we
//
// one request at a time via accept, start and decode states; a data byte then emits its samples in emit
// the last length byte of the header runs one multiply and two 42-step serial divides
// a finished lump or a rejection waits in its status state until the output slot takes the status result
// results sit in a single output register; a stalled sink holds the sample loop
// arst_n clears the controller, divider, phase and output valid; mixer_rate returns to 44100
module sound_lump_nearest_resampler_core (
	input  logic                        clk,
	input  logic                        arst_n,
	slnr_in_if.sink                     in_ch,
	slnr_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [slnr_pkg::MIX_W-1:0]  cfg_wdata
);
	slnr_pkg::cmd_t    cmd;
	slnr_pkg::status_t st;

	slnr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	slnr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);
endmodule
